// ===== hw/rtl/mqbrb_pkg.sv =====
package mqbrb_pkg;

  // default geometry
  localparam int CAPACITY_DEF   = 64;
  localparam int NUM_SLAVES_DEF = 8;
  localparam int NUM_TYPES_DEF  = 4;

  // field widths
  localparam int OP_W        = 2;
  localparam int SLAVE_W     = 3;
  localparam int TYPE_W      = 2;
  localparam int SIZE_W      = 6;
  localparam int BYTE_W      = 8;
  localparam int FILL_W      = 6;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  // input word kinds
  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_COUNT = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  // shared modular adder operation
  typedef enum logic {
    UA_ADD = 1'b0,
    UA_SUB = 1'b1
  } ua_op_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_PUSH_WR,
    S_PUSH_END,
    S_POP_ADDR,
    S_POP_OUT,
    S_RESP
  } state_e;

  // one result word
  typedef struct packed {
    logic              status;
    logic [BYTE_W-1:0] out_byte;
    logic [FILL_W-1:0] fill_count;
    logic              result_last;
  } resp_t;

endpackage

// ===== hw/rtl/multi_queue_byte_ring_buffer_unit.sv =====
// After reset the pointer stores are cleared, one ring a cycle, for NUM_SLAVES*NUM_TYPES
// rings; s_axis_tready_o stays low meanwhile. One word is handled at a time.
// Push byte: written in S_PUSH_WR; the final byte of a message then commits the write
// pointer in S_PUSH_END and gives its result. Count query and refused or zero-size pop:
// result word from S_EVAL. Pop: per byte, S_POP_ADDR steps the pointer in the shared
// modular adder and reads a byte, S_POP_OUT hands it out; backpressure stalls S_POP_OUT.
module multi_queue_byte_ring_buffer_unit
  import mqbrb_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int NUM_SLAVES = NUM_SLAVES_DEF,
  parameter int NUM_TYPES  = NUM_TYPES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // slave side
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // slave_id [2:0], queue_type [4:3], msg_size [10:5], data_byte [18:11], zero [23:19]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // op [1:0]
  input  logic [OP_W-1:0]        s_axis_tuser_i,
  input  logic                   s_axis_tlast_i,
  // master side
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // out_byte [7:0], fill_count [13:8], zero [15:14]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // status [0]
  output logic                   m_axis_tuser_o,
  output logic                   m_axis_tlast_o
);

  localparam int NQ = NUM_SLAVES * NUM_TYPES;
  localparam int PW = $clog2(CAPACITY);
  localparam int RW = (NQ > 1) ? $clog2(NQ) : 1;
  localparam int AW = $clog2(NQ * CAPACITY);
  localparam int SW = ((PW > SIZE_W) ? PW : SIZE_W) + 1;

  state_e state_q, state_d;
  logic [RW-1:0] clr_q, clr_d;

  // latched input word
  op_e               op_q, op_d;
  logic [RW-1:0]     ring_q, ring_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [BYTE_W-1:0] data_q, data_d;
  logic              last_q, last_d;

  // push message state
  logic              push_busy_q, push_busy_d;
  logic              push_acc_q, push_acc_d;
  logic [SIZE_W-1:0] stage_off_q, stage_off_d;
  logic [RW-1:0]     push_ring_q, push_ring_d;
  logic [SIZE_W-1:0] push_size_q, push_size_d;
  logic [PW-1:0]     push_wp_q, push_wp_d;

  // pop walk
  logic [PW-1:0]     cur_q, cur_d;
  logic [SIZE_W-1:0] cnt_q, cnt_d;

  resp_t resp_q, resp_d;
  resp_t out_q, out_d;
  logic  out_valid_q, out_valid_d;
  logic  out_load, out_free;

  logic [RW-1:0] ring_in;
  logic          in_accept;
  op_e           op_in;
  logic          pop_last;
  logic          pop_refuse;
  logic [PW-1:0] held;

  // memories and shared unit
  logic          ptr_re;
  logic [RW-1:0] ptr_raddr;
  logic          rp_we, wp_we;
  logic [RW-1:0] rp_waddr, wp_waddr;
  logic [PW-1:0] rp_wdata, wp_wdata, rp_rdata, wp_rdata;
  logic              byte_we, byte_re;
  logic [AW-1:0]     byte_waddr, byte_raddr;
  logic [BYTE_W-1:0] byte_rdata;
  ua_op_e        unit_op;
  logic [PW-1:0] unit_a, unit_b, unit_res;

  assign in_accept       = s_axis_tvalid_i & s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign op_in           = op_e'(s_axis_tuser_i);
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign held            = unit_res;
  assign pop_refuse      = SW'(size_q) > SW'(held);
  assign pop_last        = (cnt_q == size_q - SIZE_W'(1));

  // ring select, indexes folded into range
  always_comb begin
    ring_in = '0;
    for (int s = 0; s < 8; s++) begin
      for (int t = 0; t < 4; t++) begin
        if (s_axis_tdata_i[2:0] == 3'(s) && s_axis_tdata_i[4:3] == 2'(t)) begin
          ring_in = RW'((s % NUM_SLAVES) * NUM_TYPES + (t % NUM_TYPES));
        end
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == RW'(NQ - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept && op_in != OP_NOP) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        case (op_q)
          OP_PUSH: state_d = S_PUSH_WR;
          OP_POP: begin
            if (size_q == '0 || pop_refuse) begin
              state_d = S_RESP;
            end else begin
              state_d = S_POP_ADDR;
            end
          end
          default: state_d = S_RESP;
        endcase
      end
      S_PUSH_WR:  state_d = last_q ? S_PUSH_END : S_IDLE;
      S_PUSH_END: state_d = S_RESP;
      S_POP_ADDR: state_d = S_POP_OUT;
      S_POP_OUT: begin
        if (out_free) begin
          state_d = pop_last ? S_IDLE : S_POP_ADDR;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath control per state
  always_comb begin
    clr_d       = clr_q;
    op_d        = op_q;
    ring_d      = ring_q;
    size_d      = size_q;
    data_d      = data_q;
    last_d      = last_q;
    push_busy_d = push_busy_q;
    push_acc_d  = push_acc_q;
    stage_off_d = stage_off_q;
    push_ring_d = push_ring_q;
    push_size_d = push_size_q;
    push_wp_d   = push_wp_q;
    cur_d       = cur_q;
    cnt_d       = cnt_q;
    resp_d      = resp_q;
    out_d       = out_q;
    out_load    = 1'b0;
    ptr_re      = 1'b0;
    ptr_raddr   = ring_in;
    rp_we       = 1'b0;
    wp_we       = 1'b0;
    rp_waddr    = ring_q;
    wp_waddr    = push_ring_q;
    rp_wdata    = cur_q;
    wp_wdata    = unit_res;
    byte_we     = 1'b0;
    byte_re     = 1'b0;
    byte_waddr  = AW'(int'(push_ring_q) * CAPACITY + int'(unit_res));
    byte_raddr  = AW'(int'(ring_q) * CAPACITY + int'(cur_q));
    unit_op     = UA_ADD;
    unit_a      = '0;
    unit_b      = '0;
    case (state_q)
      // zero both pointer stores
      S_CLEAR: begin
        rp_we    = 1'b1;
        wp_we    = 1'b1;
        rp_waddr = clr_q;
        wp_waddr = clr_q;
        rp_wdata = '0;
        wp_wdata = '0;
        clr_d    = clr_q + RW'(1);
      end
      // take a word and fetch its ring pointers
      S_IDLE: begin
        if (in_accept) begin
          op_d   = op_in;
          ring_d = ring_in;
          size_d = s_axis_tdata_i[10:5];
          data_d = s_axis_tdata_i[18:11];
          last_d = s_axis_tlast_i;
          ptr_re = 1'b1;
        end
      end
      // fill level, then decide
      S_EVAL: begin
        unit_op = UA_SUB;
        unit_a  = wp_rdata;
        unit_b  = rp_rdata;
        case (op_q)
          OP_PUSH: begin
            if (!push_busy_q) begin
              push_busy_d = 1'b1;
              push_ring_d = ring_q;
              push_size_d = size_q;
              push_wp_d   = wp_rdata;
              push_acc_d  = (SW'(held) + SW'(size_q)) < SW'(CAPACITY);
              stage_off_d = '0;
            end
          end
          OP_POP: begin
            cur_d  = rp_rdata;
            cnt_d  = '0;
            resp_d = '{status: pop_refuse && size_q != '0, out_byte: '0,
                       fill_count: '0, result_last: 1'b1};
          end
          default: begin
            resp_d = '{status: 1'b0, out_byte: '0, fill_count: FILL_W'(held),
                       result_last: 1'b1};
          end
        endcase
      end
      // store one pushed byte behind the write pointer
      S_PUSH_WR: begin
        unit_a  = push_wp_q;
        unit_b  = PW'(stage_off_q);
        byte_we = push_acc_q && (stage_off_q < push_size_q);
        if (stage_off_q != '1) begin
          stage_off_d = stage_off_q + SIZE_W'(1);
        end
      end
      // commit the message and report
      S_PUSH_END: begin
        unit_a      = push_wp_q;
        unit_b      = PW'(push_size_q);
        wp_we       = push_acc_q;
        resp_d      = '{status: !push_acc_q, out_byte: '0, fill_count: '0,
                        result_last: 1'b1};
        push_busy_d = 1'b0;
        push_acc_d  = 1'b0;
        stage_off_d = '0;
      end
      // read the next byte and step the read pointer
      S_POP_ADDR: begin
        unit_a  = cur_q;
        unit_b  = PW'(1);
        byte_re = 1'b1;
        cur_d   = unit_res;
      end
      // hand the byte out, commit the read pointer on the last one
      S_POP_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d    = '{status: 1'b0, out_byte: byte_rdata, fill_count: '0,
                       result_last: pop_last};
          cnt_d    = cnt_q + SIZE_W'(1);
          rp_we    = pop_last;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d    = resp_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !m_axis_tready_i);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      push_busy_q <= 1'b0;
      push_acc_q  <= 1'b0;
      stage_off_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      push_busy_q <= push_busy_d;
      push_acc_q  <= push_acc_d;
      stage_off_q <= stage_off_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    ring_q      <= ring_d;
    size_q      <= size_d;
    data_q      <= data_d;
    last_q      <= last_d;
    push_ring_q <= push_ring_d;
    push_size_q <= push_size_d;
    push_wp_q   <= push_wp_d;
    cur_q       <= cur_d;
    cnt_q       <= cnt_d;
    resp_q      <= resp_d;
    out_q       <= out_d;
  end

  // shared modular adder
  mqbrb_modadd #(
    .MODULUS(CAPACITY)
  ) u_modadd (
    .op_i (unit_op),
    .a_i  (unit_a),
    .b_i  (unit_b),
    .res_o(unit_res)
  );

  mqbrb_ram #(
    .WIDTH(PW),
    .DEPTH(NQ)
  ) u_rp_ram (
    .clk_i  (clk_i),
    .we_i   (rp_we),
    .waddr_i(rp_waddr),
    .wdata_i(rp_wdata),
    .re_i   (ptr_re),
    .raddr_i(ptr_raddr),
    .rdata_o(rp_rdata)
  );

  mqbrb_ram #(
    .WIDTH(PW),
    .DEPTH(NQ)
  ) u_wp_ram (
    .clk_i  (clk_i),
    .we_i   (wp_we),
    .waddr_i(wp_waddr),
    .wdata_i(wp_wdata),
    .re_i   (ptr_re),
    .raddr_i(ptr_raddr),
    .rdata_o(wp_rdata)
  );

  mqbrb_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(NQ * CAPACITY)
  ) u_byte_ram (
    .clk_i  (clk_i),
    .we_i   (byte_we),
    .waddr_i(byte_waddr),
    .wdata_i(data_q),
    .re_i   (byte_re),
    .raddr_i(byte_raddr),
    .rdata_o(byte_rdata)
  );

  // output word
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_W - FILL_W - BYTE_W)'(0), out_q.fill_count,
                            out_q.out_byte};
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tlast_o  = out_q.result_last;

  // ring positions from the shared adder stay inside the ring
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL || state_q == S_POP_ADDR) |-> int'(unit_res) < CAPACITY)
    else $error("modular adder result out of ring range");

  // a pop never reads past its requested size
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP_ADDR |-> cnt_q < size_q)
    else $error("pop walk overran message size");

  // bytes land only for an accepted message in flight
  a_byte_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_we |-> (push_busy_q && push_acc_q))
    else $error("byte stored outside an accepted push");

  // closing a push frees the message state
  a_push_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PUSH_END |=> (!push_busy_q && !push_acc_q && stage_off_q == '0))
    else $error("push state not released");

  // nothing moves during the clearing pass
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> (!m_axis_tvalid_o && !s_axis_tready_o))
    else $error("traffic during pointer clear");

endmodule

// ===== hw/rtl/mqbrb_ram.sv =====
module mqbrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/mqbrb_modadd.sv =====
module mqbrb_modadd
  import mqbrb_pkg::*;
#(
  parameter int MODULUS = CAPACITY_DEF,
  localparam int W = $clog2(MODULUS)
) (
  input  ua_op_e       op_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic [W-1:0] res_o
);

  logic [W:0] sum;
  logic [W:0] diff;

  assign sum  = {1'b0, a_i} + {1'b0, b_i};
  assign diff = {1'b0, a_i} - {1'b0, b_i};

  // operands are below the modulus, so one correction step folds the result
  always_comb begin
    res_o = '0;
    case (op_i)
      UA_ADD: begin
        if (sum >= (W+1)'(MODULUS)) begin
          res_o = W'(sum - (W+1)'(MODULUS));
        end else begin
          res_o = W'(sum);
        end
      end
      UA_SUB: begin
        if (diff[W]) begin
          res_o = W'(diff + (W+1)'(MODULUS));
        end else begin
          res_o = W'(diff);
        end
      end
      default: res_o = '0;
    endcase
  end

endmodule
